FILE: hdl/dqtk_pkg.sv
// Shared types, widths and codes for the dequantising top-k selection unit.
package dqtk_pkg;

  // Field widths
  localparam int unsigned ElemW   = 32;
  localparam int unsigned ScoreW  = 48;
  localparam int unsigned IdxW    = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned TypeW   = 2;
  localparam int unsigned ZpW     = 9;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned DiffW   = 10;
  localparam int unsigned ProdW   = DiffW + ScaleW + 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegElementType = 2'd0;
  localparam logic [CfgIdxW-1:0] RegZeroOffset  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegScaleFactor = 2'd2;

  // Element type codes (the upper code bit selects fixed-point input)
  localparam logic [TypeW-1:0] TypeInt8  = 2'd0;
  localparam logic [TypeW-1:0] TypeUint8 = 2'd1;
  localparam logic [TypeW-1:0] TypeFixed = 2'd2;

  // Register reset values
  localparam logic [ScaleW-1:0] ScaleReset = 32'd16777216;

  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic        [IdxW-1:0]   idx_t;
  typedef logic        [CountW-1:0] count_t;

  // Lowest score, held by an empty slot
  localparam score_t ScoreMin = {1'b1, {(ScoreW-1){1'b0}}};

  typedef struct packed {
    logic [TypeW-1:0]  element_type;
    logic [ZpW-1:0]    zero_offset;
    logic [ScaleW-1:0] scale_factor;
  } cfg_t;

  // Update request towards the best list
  typedef struct packed {
    logic step;   // take the score in this cycle
    logic clear;  // last element: empty the list after this step
  } list_ctrl_t;

endpackage

FILE: hdl/dqtk_dequant.sv
// Dequantisation stage: raw element to signed Q23.24 score, registered.
module dqtk_dequant (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  dqtk_pkg::cfg_t              cfg_i,
  input  logic [dqtk_pkg::ElemW-1:0]  element_i,
  output dqtk_pkg::score_t            score_o
);

  logic signed [dqtk_pkg::DiffW-1:0] code;
  logic signed [dqtk_pkg::DiffW-1:0] zp;
  logic signed [dqtk_pkg::DiffW-1:0] diff;
  logic signed [dqtk_pkg::ProdW-1:0] prod;
  dqtk_pkg::score_t                  score_d;
  dqtk_pkg::score_t                  score_q;

  // Extend the 8-bit code by type and remove the zero point
  always_comb begin
    if (cfg_i.element_type == dqtk_pkg::TypeInt8) begin
      code = {{2{element_i[7]}}, element_i[7:0]};
    end else begin
      code = {2'b00, element_i[7:0]};
    end
    zp   = {cfg_i.zero_offset[dqtk_pkg::ZpW-1], cfg_i.zero_offset};
    diff = code - zp;
    prod = diff * $signed({1'b0, cfg_i.scale_factor});
  end

  // Fixed-point elements pass through sign-extended
  always_comb begin
    if (cfg_i.element_type[1]) begin
      score_d = {{(dqtk_pkg::ScoreW-dqtk_pkg::ElemW){element_i[dqtk_pkg::ElemW-1]}},
                 element_i};
    end else begin
      score_d = {{(dqtk_pkg::ScoreW-dqtk_pkg::ProdW){prod[dqtk_pkg::ProdW-1]}}, prod};
    end
  end

  // Hold the score for the list stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      score_q <= score_d;
    end
  end

  assign score_o = score_q;

endmodule

FILE: hdl/dqtk_list.sv
// Sorted best list: parallel compare, insertion shift and element counter.
module dqtk_list #(
  parameter int unsigned TOP_K       = 5,
  parameter int unsigned MAX_CLASSES = 65536
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dqtk_pkg::list_ctrl_t               ctrl_i,
  input  dqtk_pkg::score_t                   score_i,
  output dqtk_pkg::score_t                   nxt_score_o [TOP_K],
  output dqtk_pkg::idx_t                     nxt_idx_o   [TOP_K],
  output logic [$clog2(TOP_K+1)-1:0]         nxt_filled_o,
  output dqtk_pkg::count_t                   nxt_count_o
);

  localparam int unsigned CntW = $clog2(TOP_K+1);

  dqtk_pkg::score_t       best_score_q [TOP_K];
  dqtk_pkg::idx_t         best_idx_q   [TOP_K];
  logic [CntW-1:0]        filled_q;
  dqtk_pkg::count_t       count_q;

  dqtk_pkg::score_t       ins_score [TOP_K];
  dqtk_pkg::idx_t         ins_idx   [TOP_K];
  logic [TOP_K-1:0]       gt;
  logic                   counted;
  dqtk_pkg::idx_t         cur_idx;

  assign counted = count_q < dqtk_pkg::CountW'(MAX_CLASSES);
  assign cur_idx = count_q[dqtk_pkg::IdxW-1:0];

  // Compare against every slot and shift the tail down by one
  for (genvar k = 0; k < TOP_K; k++) begin : g_slot
    assign gt[k] = score_i > best_score_q[k];
    if (k == 0) begin : g_head
      assign ins_score[k] = gt[k] ? score_i : best_score_q[k];
      assign ins_idx[k]   = gt[k] ? cur_idx : best_idx_q[k];
    end else begin : g_tail
      assign ins_score[k] = !gt[k] ? best_score_q[k] :
                            gt[k-1] ? best_score_q[k-1] : score_i;
      assign ins_idx[k]   = !gt[k] ? best_idx_q[k] :
                            gt[k-1] ? best_idx_q[k-1] : cur_idx;
    end
  end

  // Select the list after this element; beyond the class limit keep it
  always_comb begin
    for (int k = 0; k < TOP_K; k++) begin
      nxt_score_o[k] = counted ? ins_score[k] : best_score_q[k];
      nxt_idx_o[k]   = counted ? ins_idx[k]   : best_idx_q[k];
    end
    nxt_filled_o = filled_q;
    if (counted && (|gt) && (filled_q < CntW'(TOP_K))) begin
      nxt_filled_o = filled_q + CntW'(1);
    end
    nxt_count_o = counted ? count_q + dqtk_pkg::CountW'(1) : count_q;
  end

  // Advance the list, or clear it after the last element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOP_K; k++) begin
        best_score_q[k] <= dqtk_pkg::ScoreMin;
        best_idx_q[k]   <= '0;
      end
      filled_q <= '0;
      count_q  <= '0;
    end else if (ctrl_i.step) begin
      if (ctrl_i.clear) begin
        for (int k = 0; k < TOP_K; k++) begin
          best_score_q[k] <= dqtk_pkg::ScoreMin;
          best_idx_q[k]   <= '0;
        end
        filled_q <= '0;
        count_q  <= '0;
      end else begin
        for (int k = 0; k < TOP_K; k++) begin
          best_score_q[k] <= nxt_score_o[k];
          best_idx_q[k]   <= nxt_idx_o[k];
        end
        filled_q <= nxt_filled_o;
        count_q  <= nxt_count_o;
      end
    end
  end

endmodule

FILE: hdl/dequant_top_k_select_unit.sv
// Top level of the dequantising streaming top-k selection unit.
//
// Input channel: one vector element per transaction (element_i, final_element_i),
// handshake in_valid_i / in_stall_o. Output channel: one ranked entry per
// transaction (rank_o, class_index_o, score_o, class_count_o, last_result_o),
// handshake out_valid_o / out_stall_i. Registers are written via cfg_we_i,
// cfg_idx_i and cfg_wdata_i by the user, only while no vector is in flight;
// the block itself does not enforce this. An element enters an input register,
// is dequantised into a score register (one multiplier) and from there is
// inserted in the sorted list (TOP_K parallel compares). Throughput is one
// element per cycle while the input does not stall. On the final element the
// updated list is copied to an output buffer and the list clears at once, so
// the next vector can stream in immediately. The buffer then shifts out one
// result per cycle while the output does not stall, best first. A final
// element that reaches the list while the buffer still holds an earlier list
// waits there, and the input stalls behind it. A stall on the output holds
// the current result; elements keep entering until the pipeline fills.
// Reset empties the pipeline, the list and the buffer and loads the register
// defaults (signed 8-bit, zero offset 0, scale 1.0).
module dequant_top_k_select_unit #(
  parameter int unsigned TOP_K       = 5,
  parameter int unsigned MAX_CLASSES = 65536
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [dqtk_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [dqtk_pkg::CfgDataW-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [dqtk_pkg::ElemW-1:0]     element_i,
  input  logic                                  final_element_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [((TOP_K > 1) ? $clog2(TOP_K) : 1)-1:0] rank_o,
  output logic [dqtk_pkg::IdxW-1:0]             class_index_o,
  output logic signed [dqtk_pkg::ScoreW-1:0]    score_o,
  output logic [dqtk_pkg::CountW-1:0]           class_count_o,
  output logic                                  last_result_o
);

  localparam int unsigned RankW = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned CntW  = $clog2(TOP_K+1);

  dqtk_pkg::cfg_t              cfg_q;
  logic                        s1_vld_q;
  logic [dqtk_pkg::ElemW-1:0]  s1_elem_q;
  logic                        s1_final_q;
  logic                        s2_vld_q;
  logic                        s2_final_q;
  dqtk_pkg::score_t            s2_score;
  logic                        s1_adv;
  logic                        s2_adv;
  logic                        s2_fire;
  logic                        snap_free;
  logic                        snap_load;
  logic                        out_fire;
  dqtk_pkg::list_ctrl_t        list_ctrl;

  dqtk_pkg::score_t            nxt_score [TOP_K];
  dqtk_pkg::idx_t              nxt_idx   [TOP_K];
  logic [CntW-1:0]             nxt_filled;
  dqtk_pkg::count_t            nxt_count;

  dqtk_pkg::score_t            snap_score_q [TOP_K];
  dqtk_pkg::idx_t              snap_idx_q   [TOP_K];
  dqtk_pkg::count_t            snap_count_q;
  logic [CntW-1:0]             snap_left_q;
  logic [RankW-1:0]            snap_rank_q;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.element_type <= dqtk_pkg::TypeInt8;
      cfg_q.zero_offset  <= '0;
      cfg_q.scale_factor <= dqtk_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dqtk_pkg::RegElementType: begin
          cfg_q.element_type <= cfg_wdata_i[dqtk_pkg::TypeW-1:0];
        end
        dqtk_pkg::RegZeroOffset: begin
          cfg_q.zero_offset <= cfg_wdata_i[dqtk_pkg::ZpW-1:0];
        end
        dqtk_pkg::RegScaleFactor: begin
          cfg_q.scale_factor <= cfg_wdata_i[dqtk_pkg::ScaleW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: a final element waits for a free output buffer
  assign out_fire  = out_valid_o && !out_stall_i;
  assign snap_free = (snap_left_q == '0) ||
                     (out_fire && (snap_left_q == CntW'(1)));
  assign s2_fire   = s2_vld_q && (!s2_final_q || snap_free);
  assign s2_adv    = !s2_vld_q || s2_fire;
  assign s1_adv    = !s1_vld_q || s2_adv;
  assign in_stall_o = !s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      s1_elem_q  <= element_i;
      s1_final_q <= final_element_i;
    end
  end

  // Score register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_vld_q) begin
      s2_final_q <= s1_final_q;
    end
  end

  dqtk_dequant u_dequant (
    .clk_i     (clk_i),
    .load_i    (s2_adv && s1_vld_q),
    .cfg_i     (cfg_q),
    .element_i (s1_elem_q),
    .score_o   (s2_score)
  );

  assign list_ctrl.step  = s2_fire;
  assign list_ctrl.clear = s2_final_q;

  dqtk_list #(
    .TOP_K       (TOP_K),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_list (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (list_ctrl),
    .score_i      (s2_score),
    .nxt_score_o  (nxt_score),
    .nxt_idx_o    (nxt_idx),
    .nxt_filled_o (nxt_filled),
    .nxt_count_o  (nxt_count)
  );

  assign snap_load = s2_fire && s2_final_q;

  // Output buffer control: load a finished list, count down per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_left_q <= '0;
      snap_rank_q <= '0;
    end else if (snap_load) begin
      snap_left_q <= nxt_filled;
      snap_rank_q <= '0;
    end else if (out_fire) begin
      snap_left_q <= snap_left_q - CntW'(1);
      snap_rank_q <= snap_rank_q + RankW'(1);
    end
  end

  // Output buffer payload: shift towards the head on each transaction
  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      for (int k = 0; k < TOP_K; k++) begin
        snap_score_q[k] <= nxt_score[k];
        snap_idx_q[k]   <= nxt_idx[k];
      end
      snap_count_q <= nxt_count;
    end else if (out_fire) begin
      for (int k = 0; k < TOP_K - 1; k++) begin
        snap_score_q[k] <= snap_score_q[k+1];
        snap_idx_q[k]   <= snap_idx_q[k+1];
      end
    end
  end

  assign out_valid_o   = snap_left_q != '0;
  assign rank_o        = snap_rank_q;
  assign class_index_o = snap_idx_q[0];
  assign score_o       = snap_score_q[0];
  assign class_count_o = snap_count_q;
  assign last_result_o = snap_left_q == CntW'(1);

endmodule

FILE: hdl/dqtk_checker.sv
// Port-level assertions for the top-k selection unit, bound to the top level.
module dqtk_checker #(
  parameter int unsigned RANK_W = 3
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [RANK_W-1:0]                  rank_o,
  input logic [dqtk_pkg::IdxW-1:0]          class_index_o,
  input logic signed [dqtk_pkg::ScoreW-1:0] score_o,
  input logic [dqtk_pkg::CountW-1:0]        class_count_o,
  input logic                               last_result_o
);

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_o) &&
    $stable(class_index_o) && $stable(rank_o))
    else $error("stalled result changed");

  // A list is delivered without gaps until its last entry
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o)
    else $error("gap inside a result list");

  // Ranks count up within a list
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
    rank_o == $past(rank_o) + RANK_W'(1))
    else $error("rank did not advance by one");

  // Class count is shared by every entry of a list
  a_count_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=>
    class_count_o == $past(class_count_o))
    else $error("class count changed within a list");

  // Entries after the first never outscore their predecessor
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> score_o <= $past(score_o))
    else $error("result list not sorted");

endmodule

bind dequant_top_k_select_unit dqtk_checker #(
  .RANK_W (RankW)
) u_dqtk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .rank_o        (rank_o),
  .class_index_o (class_index_o),
  .score_o       (score_o),
  .class_count_o (class_count_o),
  .last_result_o (last_result_o)
);

FILE: sim/tb_dequant_top_k_select_unit.sv
// Self-checking testbench for the dequantising streaming top-k selection unit.
`timescale 1ns / 1ps

module tb_dequant_top_k_select_unit;

  localparam int unsigned TOP_K        = 5;
  localparam int unsigned MAX_CLASSES  = 65536;
  localparam int unsigned RankW        = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 20000;

  typedef struct {
    logic [dqtk_pkg::ElemW-1:0] element;
    logic                       last_elem;
    int unsigned                gap;
  } elem_item_t;

  typedef struct {
    logic [RankW-1:0]  rank;
    dqtk_pkg::idx_t    class_index;
    dqtk_pkg::score_t  score;
    dqtk_pkg::count_t  class_count;
    logic              last_result;
  } ranked_entry_t;

  // Clock, reset and block ports
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [dqtk_pkg::CfgIdxW-1:0]  cfg_idx_i       = '0;
  logic [dqtk_pkg::CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [dqtk_pkg::ElemW-1:0]    element_i       = '0;
  logic                          final_element_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic [RankW-1:0]              rank_o;
  dqtk_pkg::idx_t                class_index_o;
  dqtk_pkg::score_t              score_o;
  dqtk_pkg::count_t              class_count_o;
  logic                          last_result_o;

  // Stimulus and scoreboard state
  elem_item_t    pending_elements[$];
  ranked_entry_t expected_ranked[$];
  elem_item_t    next_item;
  int unsigned   queued_count    = 0;
  int unsigned   accepted_count  = 0;
  int unsigned   err_count       = 0;
  int unsigned   tx_gap_left     = 0;
  int unsigned   rx_stall_left   = 0;
  int unsigned   hold_left       = 0;
  int unsigned   hold_req_count  = 0;
  int unsigned   hold_done_count = 0;
  bit            tx_idle_en      = 1'b1;
  bit            rx_idle_en      = 1'b1;

  // Predictor copy of the registers and the best list
  logic [dqtk_pkg::TypeW-1:0]         mdl_type;
  logic signed [dqtk_pkg::ZpW-1:0]    mdl_zp;
  logic [dqtk_pkg::ScaleW-1:0]        mdl_scale;
  dqtk_pkg::score_t                   top_score [TOP_K];
  dqtk_pkg::idx_t                     top_index [TOP_K];
  int unsigned                        filled;
  dqtk_pkg::count_t                   seen_count;

  dequant_top_k_select_unit #(
    .TOP_K       (TOP_K),
    .MAX_CLASSES (MAX_CLASSES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .element_i       (element_i),
    .final_element_i (final_element_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .rank_o          (rank_o),
    .class_index_o   (class_index_o),
    .score_o         (score_o),
    .class_count_o   (class_count_o),
    .last_result_o   (last_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // ---------------------------------------------------------------- predictor

  function automatic dqtk_pkg::score_t dequant_score(logic [dqtk_pkg::ElemW-1:0] raw);
    logic signed [dqtk_pkg::DiffW-1:0] code;
    logic signed [dqtk_pkg::DiffW-1:0] diff;
    longint                            prod;
    if (mdl_type[1]) return dqtk_pkg::score_t'($signed(raw));
    if (mdl_type == dqtk_pkg::TypeInt8) code = {{2{raw[7]}}, raw[7:0]};
    else code = {2'b00, raw[7:0]};
    diff = code - mdl_zp;
    prod = longint'(diff) * longint'({1'b0, mdl_scale});
    return dqtk_pkg::score_t'(prod);
  endfunction

  task automatic clear_list();
    int k;
    for (k = 0; k < TOP_K; k++) begin
      top_score[k] = dqtk_pkg::ScoreMin;
      top_index[k] = '0;
    end
    filled     = 0;
    seen_count = '0;
  endtask

  // Insert by strict comparison so that the earlier index keeps a tie
  task automatic insert_ranked(dqtk_pkg::score_t s, dqtk_pkg::idx_t idx);
    int k;
    int j;
    bit placed;
    placed = 1'b0;
    for (k = 0; k < TOP_K; k++) begin
      if (!placed && s > top_score[k]) begin
        for (j = TOP_K - 1; j > k; j--) begin
          top_score[j] = top_score[j-1];
          top_index[j] = top_index[j-1];
        end
        top_score[k] = s;
        top_index[k] = idx;
        if (filled < TOP_K) filled++;
        placed = 1'b1;
      end
    end
  endtask

  task automatic predict_element(logic [dqtk_pkg::ElemW-1:0] raw, logic last_elem);
    ranked_entry_t r;
    int unsigned   k;
    if (seen_count < MAX_CLASSES) begin
      insert_ranked(dequant_score(raw), dqtk_pkg::idx_t'(seen_count));
      seen_count++;
    end
    if (last_elem) begin
      for (k = 0; k < filled; k++) begin
        r.rank        = RankW'(k);
        r.class_index = top_index[k];
        r.score       = top_score[k];
        r.class_count = seen_count;
        r.last_result = (k + 1 == filled);
        expected_ranked.push_back(r);
      end
      clear_list();
    end
  endtask

  // Track register writes and accepted elements
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdl_type  = dqtk_pkg::TypeInt8;
      mdl_zp    = '0;
      mdl_scale = dqtk_pkg::ScaleReset;
      clear_list();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dqtk_pkg::RegElementType: mdl_type  = cfg_wdata_i[dqtk_pkg::TypeW-1:0];
          dqtk_pkg::RegZeroOffset:  mdl_zp    = cfg_wdata_i[dqtk_pkg::ZpW-1:0];
          dqtk_pkg::RegScaleFactor: mdl_scale = cfg_wdata_i[dqtk_pkg::ScaleW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        predict_element(element_i, final_element_i);
        accepted_count++;
      end
    end
  end

  // ------------------------------------------------------------------ driver

  // Present the next pending element once the current one has gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      element_i       <= '0;
      final_element_i <= 1'b0;
      tx_gap_left     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (tx_gap_left != 0) begin
        tx_gap_left <= tx_gap_left - 1;
        in_valid_i  <= 1'b0;
      end else if (pending_elements.size() != 0) begin
        next_item        = pending_elements.pop_front();
        in_valid_i      <= 1'b1;
        element_i       <= next_item.element;
        final_element_i <= next_item.last_elem;
        tx_gap_left     <= next_item.gap;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: random gaps, plus a long hold when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      rx_stall_left <= 0;
      hold_left     <= 0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_done_count != hold_req_count && out_valid_o) begin
      hold_left       <= HoldCycles;
      hold_done_count <= hold_done_count + 1;
      out_stall_i     <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_stall_i   <= 1'b1;
    end else begin
      out_stall_i   <= 1'b0;
      rx_stall_left <= rx_idle_en ? pick_gap() : 0;
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_ranked.size() == 0) begin
        $error("result with nothing expected: rank %0d index %0d score %0d",
               rank_o, class_index_o, score_o);
        err_count++;
      end else begin
        ranked_entry_t e;
        e = expected_ranked.pop_front();
        if (rank_o !== e.rank) begin
          $error("rank: expected %0d, got %0d", e.rank, rank_o);
          err_count++;
        end
        if (class_index_o !== e.class_index) begin
          $error("class_index: expected %0d, got %0d", e.class_index, class_index_o);
          err_count++;
        end
        if (score_o !== e.score) begin
          $error("score: expected %0d, got %0d", e.score, score_o);
          err_count++;
        end
        if (class_count_o !== e.class_count) begin
          $error("class_count: expected %0d, got %0d", e.class_count, class_count_o);
          err_count++;
        end
        if (last_result_o !== e.last_result) begin
          $error("last_result: expected %0d, got %0d", e.last_result, last_result_o);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic write_reg(logic [dqtk_pkg::CfgIdxW-1:0] idx,
                           logic [dqtk_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic write_all(logic [dqtk_pkg::TypeW-1:0] etype, int zp,
                           logic [dqtk_pkg::ScaleW-1:0] scale);
    write_reg(dqtk_pkg::RegElementType,
              {{(dqtk_pkg::CfgDataW-dqtk_pkg::TypeW){1'b0}}, etype});
    write_reg(dqtk_pkg::RegZeroOffset,
              {{(dqtk_pkg::CfgDataW-dqtk_pkg::ZpW){1'b0}}, dqtk_pkg::ZpW'(zp)});
    write_reg(dqtk_pkg::RegScaleFactor, scale);
  endtask

  task automatic push_item(logic [dqtk_pkg::ElemW-1:0] word, logic last_elem);
    elem_item_t it;
    it.element   = word;
    it.last_elem = last_elem;
    it.gap       = tx_idle_en ? pick_gap() : 0;
    pending_elements.push_back(it);
    queued_count++;
  endtask

  // Wait for every element to go in and every result to come out
  task automatic drain();
    int unsigned waited;
    waited = 0;
    while (accepted_count != queued_count) @(posedge clk_i);
    while (expected_ranked.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_ranked.size() != 0) begin
      $error("%0d expected results never arrived", expected_ranked.size());
      err_count++;
      expected_ranked.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random element: extremes, a narrow band for ties, or anything
  function automatic logic [dqtk_pkg::ElemW-1:0] gen_element(
      logic [dqtk_pkg::TypeW-1:0] etype);
    int unsigned                r;
    logic [dqtk_pkg::ElemW-1:0] word;
    r    = $urandom_range(0, 99);
    word = $urandom;
    if (etype[1]) begin
      if (r < 10) begin
        case ($urandom_range(0, 3))
          0: word = 32'h7FFF_FFFF;
          1: word = 32'h8000_0000;
          2: word = 32'h0000_0000;
          default: word = 32'hFFFF_FFFF;
        endcase
      end else if (r < 30) begin
        word = $urandom_range(0, 3);
      end
    end else begin
      if (r < 10) begin
        case ($urandom_range(0, 3))
          0: word[7:0] = 8'h00;
          1: word[7:0] = 8'h7F;
          2: word[7:0] = 8'h80;
          default: word[7:0] = 8'hFF;
        endcase
      end else if (r < 30) begin
        word[7:0] = 8'($urandom_range(0, 3));
      end
    end
    return word;
  endfunction

  task automatic push_vector(int unsigned len, logic [dqtk_pkg::TypeW-1:0] etype);
    int unsigned i;
    for (i = 0; i < len; i++) push_item(gen_element(etype), i == len - 1);
  endtask

  task automatic random_phase(int unsigned n_items);
    logic [dqtk_pkg::TypeW-1:0]  etype;
    int                          zp;
    logic [dqtk_pkg::ScaleW-1:0] scale;
    int unsigned                 r;
    int unsigned                 sent;
    int unsigned                 len;
    etype = dqtk_pkg::TypeW'($urandom_range(0, 3));
    r     = $urandom_range(0, 99);
    if (r < 10) zp = -128;
    else if (r < 20) zp = 255;
    else zp = int'($urandom_range(0, 383)) - 128;
    r = $urandom_range(0, 99);
    if (r < 15) scale = '0;
    else if (r < 30) scale = '1;
    else if (r < 50) scale = dqtk_pkg::ScaleReset;
    else if (r < 75) scale = $urandom_range(0, 65535);
    else scale = $urandom;
    write_all(etype, zp, scale);
    tx_idle_en = ($urandom_range(0, 3) != 0);
    rx_idle_en = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      push_vector(len, etype);
      sent += len;
    end
    drain();
  endtask

  initial begin
    int unsigned i;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: signed codes with junk in the upper bits, ties, negative extreme
    push_item(32'hABCD_EF80, 1'b0);
    push_item(32'h0000_007F, 1'b0);
    push_item(32'h1234_5600, 1'b0);
    push_item(32'hFFFF_FF7F, 1'b0);
    push_item(32'h0000_00FF, 1'b0);
    push_item(32'h5555_5501, 1'b0);
    push_item(32'h0000_0080, 1'b0);
    push_item(32'h0000_007F, 1'b1);
    // Single-element vector
    push_item(32'h0000_0000, 1'b1);
    drain();

    // Unsigned codes, largest zero point and scale
    write_all(dqtk_pkg::TypeUint8, 255, 32'hFFFF_FFFF);
    push_item(32'h0000_00FF, 1'b0);
    push_item(32'hFFFF_FF00, 1'b0);
    push_item(32'h0000_0080, 1'b0);
    push_item(32'h0000_00FF, 1'b1);
    drain();

    // Zero scale: every score ties, so the earliest indices hold the list
    write_all(dqtk_pkg::TypeInt8, -128, 32'h0000_0000);
    push_item(32'h0000_007F, 1'b0);
    push_item(32'h0000_0080, 1'b0);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'h0000_00FF, 1'b0);
    push_item(32'h0000_0042, 1'b1);
    drain();

    // Fixed-point input at its extremes
    write_all(dqtk_pkg::TypeFixed, 0, dqtk_pkg::ScaleReset);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0);
    push_item(32'h0000_0000, 1'b1);
    drain();

    // Unused type code behaves as fixed point
    write_reg(dqtk_pkg::RegElementType, 32'd3);
    push_item(32'h0000_0001, 1'b0);
    push_item(32'hFFFF_FF00, 1'b1);
    drain();

    // Random settings and vectors
    for (i = 0; i < 4; i++) random_phase(40);

    // Hold the output long while short vectors keep streaming in
    hold_req_count++;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    for (i = 0; i < 25; i++) push_vector($urandom_range(1, 4), mdl_type);
    drain();

    for (i = 0; i < 4; i++) random_phase(40);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
